/* hw/rtl/arl_pkg.sv */
// Package for the address range tag lookup block.
// Holds field widths, stream packing positions, mode and state codes, and the
// command/status structs shared by the controller and the datapath.
package arl_pkg;

    localparam int unsigned DEFAULT_TABLE_DEPTH = 4096;

    // Field widths
    localparam int MODE_W = 2;
    localparam int ADDR_W = 64;
    localparam int TAG_W  = 20;
    localparam int HELD_W = 13;

    // Input stream packing, lowest bit first; mode travels alone on tuser
    localparam int S_TUSER_W   = MODE_W;
    localparam int S_EADDR_LSB = 0;
    localparam int S_ETAG_LSB  = S_EADDR_LSB + ADDR_W;
    localparam int S_QADDR_LSB = S_ETAG_LSB + TAG_W;
    localparam int S_USED_W    = S_QADDR_LSB + ADDR_W;
    localparam int S_TDATA_W   = ((S_USED_W + 7) / 8) * 8;

    // Output stream packing, lowest bit first
    localparam int M_FOUND_LSB = 0;
    localparam int M_FTAG_LSB  = M_FOUND_LSB + 1;
    localparam int M_DROP_LSB  = M_FTAG_LSB + TAG_W;
    localparam int M_HELD_LSB  = M_DROP_LSB + 1;
    localparam int M_USED_W    = M_HELD_LSB + HELD_W;
    localparam int M_TDATA_W   = ((M_USED_W + 7) / 8) * 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD   = 2'd0,
        MODE_LOOKUP = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SEARCH,
        ST_LOOK_KEY,
        ST_SEARCH2,
        ST_LOOK_TAG,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_FINISH
    } state_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LATCH,
        OP_START_LOAD,
        OP_START_LOOK,
        OP_START_EXACT,
        OP_STEP,
        OP_RD_PREV,
        OP_RD_TAG,
        OP_SET_FOUND,
        OP_SET_DROP,
        OP_SH_INIT,
        OP_SH_RD,
        OP_SH_WR,
        OP_INSERT,
        OP_CLEAR,
        OP_OUT_LOAD
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  full;
        logic  query_zero;
        logic  few_entries;
        logic  search_done;
        logic  lo_zero;
        logic  lo_at_count;
        logic  key_match;
        logic  shift_more;
        logic  out_busy;
    } dp_status_t;

endpackage

/* hw/rtl/arl_ctrl.sv */
// Controller state machine for the address range tag lookup block.
// Sequences searches, shifts and result hand-off; depends on arl_pkg.
module arl_ctrl
    import arl_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                unique case (status.mode)
                    MODE_LOAD:   state_next = status.full ? ST_FINISH : ST_SEARCH;
                    MODE_LOOKUP: state_next = (status.query_zero || status.few_entries)
                                              ? ST_FINISH : ST_SEARCH;
                    MODE_CLEAR:  state_next = ST_FINISH;
                    MODE_NONE:   state_next = ST_FINISH;
                    default:     state_next = ST_FINISH;
                endcase
            end
            ST_SEARCH: begin
                if (status.search_done) begin
                    if (status.mode == MODE_LOAD) state_next = ST_SHIFT_RD;
                    else if (status.lo_zero)      state_next = ST_FINISH;
                    else                          state_next = ST_LOOK_KEY;
                end
            end
            ST_LOOK_KEY: begin
                state_next = (status.lo_at_count && !status.key_match)
                             ? ST_FINISH : ST_SEARCH2;
            end
            ST_SEARCH2: begin
                if (status.search_done) state_next = ST_LOOK_TAG;
            end
            ST_LOOK_TAG: state_next = ST_FINISH;
            ST_SHIFT_RD: state_next = status.shift_more ? ST_SHIFT_WR : ST_FINISH;
            ST_SHIFT_WR: state_next = ST_SHIFT_RD;
            ST_FINISH: begin
                if (!status.out_busy) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        cmd.op = OP_NOP;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) cmd.op = OP_LATCH;
            end
            ST_DISPATCH: begin
                unique case (status.mode)
                    MODE_LOAD:   cmd.op = status.full ? OP_SET_DROP : OP_START_LOAD;
                    MODE_LOOKUP: cmd.op = (status.query_zero || status.few_entries)
                                          ? OP_NOP : OP_START_LOOK;
                    MODE_CLEAR:  cmd.op = OP_CLEAR;
                    MODE_NONE:   cmd.op = OP_NOP;
                    default:     cmd.op = OP_NOP;
                endcase
            end
            ST_SEARCH: begin
                if (!status.search_done)          cmd.op = OP_STEP;
                else if (status.mode == MODE_LOAD) cmd.op = OP_SH_INIT;
                else if (!status.lo_zero)          cmd.op = OP_RD_PREV;
            end
            ST_LOOK_KEY: begin
                if (!(status.lo_at_count && !status.key_match)) cmd.op = OP_START_EXACT;
            end
            ST_SEARCH2:  cmd.op = status.search_done ? OP_RD_TAG : OP_STEP;
            ST_LOOK_TAG: cmd.op = OP_SET_FOUND;
            ST_SHIFT_RD: cmd.op = status.shift_more ? OP_SH_RD : OP_INSERT;
            ST_SHIFT_WR: cmd.op = OP_SH_WR;
            ST_FINISH: begin
                if (!status.out_busy) cmd.op = OP_OUT_LOAD;
            end
            default: cmd.op = OP_NOP;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

/* hw/rtl/arl_dp.sv */
// Datapath for the address range tag lookup block: entry memories, search
// bounds, shift pointer, entry count and the result register; uses arl_pkg.
module arl_dp
    import arl_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  dp_cmd_t           cmd,
    output dp_status_t        status,
    input  logic [MODE_W-1:0] mode,
    input  logic [ADDR_W-1:0] entry_address,
    input  logic [TAG_W-1:0]  entry_tag,
    input  logic [ADDR_W-1:0] query_address,
    input  logic              m_tready,
    output logic              m_tvalid,
    output logic              found,
    output logic [TAG_W-1:0]  found_tag,
    output logic              dropped,
    output logic [HELD_W-1:0] entries_held
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Entry memories
    logic [ADDR_W-1:0] addr_mem [TABLE_DEPTH];
    logic [TAG_W-1:0]  tag_mem  [TABLE_DEPTH];
    logic [ADDR_W-1:0] rd_addr_data_reg;
    logic [TAG_W-1:0]  rd_tag_data_reg;

    // Request fields
    mode_t             mode_reg;
    logic [ADDR_W-1:0] eaddr_reg;
    logic [TAG_W-1:0]  etag_reg;
    logic [ADDR_W-1:0] query_reg;

    // Search and shift state
    logic [ADDR_W-1:0] key_reg;
    logic              above_reg;
    logic [CNT_W-1:0]  lo_reg;
    logic [CNT_W-1:0]  hi_reg;
    logic [CNT_W-1:0]  lo_next;
    logic [CNT_W-1:0]  hi_next;
    logic [CNT_W-1:0]  sh_idx_reg;
    logic [CNT_W-1:0]  count_reg;

    // Result and output registers
    logic              found_reg;
    logic [TAG_W-1:0]  ftag_reg;
    logic              drop_reg;
    logic              m_tvalid_reg;
    logic              m_found_reg;
    logic [TAG_W-1:0]  m_ftag_reg;
    logic              m_drop_reg;
    logic [HELD_W-1:0] m_held_reg;

    // Memory port controls
    logic              rd_en;
    logic [IDX_W-1:0]  rd_idx;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [ADDR_W-1:0] wr_addr_data;
    logic [TAG_W-1:0]  wr_tag_data;

    logic [CNT_W:0]    cur_sum;
    logic [CNT_W-1:0]  cur_mid;
    logic [CNT_W:0]    nxt_sum;
    logic [CNT_W-1:0]  start_mid;
    logic              go_left;

    // Midpoint of the current bounds and one search step
    assign cur_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign cur_mid   = cur_sum[CNT_W:1];
    assign start_mid = count_reg >> 1;
    assign go_left   = above_reg ? (rd_addr_data_reg > key_reg)
                                 : (rd_addr_data_reg >= key_reg);

    always_comb begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (go_left) begin
            hi_next = cur_mid;
        end else begin
            lo_next = cur_mid + CNT_W'(1);
        end
    end

    assign nxt_sum = {1'b0, lo_next} + {1'b0, hi_next};

    // Select memory read and write addresses
    always_comb begin
        rd_en        = 1'b0;
        rd_idx       = '0;
        wr_en        = 1'b0;
        wr_idx       = sh_idx_reg[IDX_W-1:0];
        wr_addr_data = rd_addr_data_reg;
        wr_tag_data  = rd_tag_data_reg;
        unique case (cmd.op)
            OP_START_LOAD, OP_START_LOOK, OP_START_EXACT: begin
                rd_en  = 1'b1;
                rd_idx = start_mid[IDX_W-1:0];
            end
            OP_STEP: begin
                rd_en  = 1'b1;
                rd_idx = nxt_sum[IDX_W:1];
            end
            OP_RD_PREV: begin
                rd_en  = 1'b1;
                rd_idx = IDX_W'(lo_reg - CNT_W'(1));
            end
            OP_RD_TAG: begin
                rd_en  = 1'b1;
                rd_idx = lo_reg[IDX_W-1:0];
            end
            OP_SH_RD: begin
                rd_en  = 1'b1;
                rd_idx = IDX_W'(sh_idx_reg - CNT_W'(1));
            end
            OP_SH_WR: begin
                wr_en = 1'b1;
            end
            OP_INSERT: begin
                wr_en        = 1'b1;
                wr_idx       = lo_reg[IDX_W-1:0];
                wr_addr_data = eaddr_reg;
                wr_tag_data  = etag_reg;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Write and read the entry memories
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            addr_mem[wr_idx] <= wr_addr_data;
            tag_mem[wr_idx]  <= wr_tag_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_addr_data_reg <= addr_mem[rd_idx];
            rd_tag_data_reg  <= tag_mem[rd_idx];
        end
    end

    // Capture the request, start and advance search bounds, and move the shift pointer
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_LATCH: begin
                mode_reg  <= mode_t'(mode);
                eaddr_reg <= entry_address;
                etag_reg  <= entry_tag;
                query_reg <= query_address;
            end
            OP_START_LOAD: begin
                key_reg   <= eaddr_reg;
                above_reg <= 1'b1;
                lo_reg    <= '0;
                hi_reg    <= count_reg;
            end
            OP_START_LOOK: begin
                key_reg   <= query_reg;
                above_reg <= 1'b1;
                lo_reg    <= '0;
                hi_reg    <= count_reg;
            end
            OP_START_EXACT: begin
                key_reg   <= rd_addr_data_reg;
                above_reg <= 1'b0;
                lo_reg    <= '0;
                hi_reg    <= count_reg;
            end
            OP_STEP: begin
                lo_reg <= lo_next;
                hi_reg <= hi_next;
            end
            OP_SH_INIT: sh_idx_reg <= count_reg;
            OP_SH_WR:   sh_idx_reg <= sh_idx_reg - CNT_W'(1);
            default: begin
                sh_idx_reg <= sh_idx_reg;
            end
        endcase
    end

    // Track entry count and per-request flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.op == OP_INSERT) begin
            count_reg <= count_reg + CNT_W'(1);
        end else if (cmd.op == OP_CLEAR) begin
            count_reg <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_LATCH: begin
                found_reg <= 1'b0;
                ftag_reg  <= '0;
                drop_reg  <= 1'b0;
            end
            OP_SET_FOUND: begin
                found_reg <= 1'b1;
                ftag_reg  <= rd_tag_data_reg;
            end
            OP_SET_DROP: drop_reg <= 1'b1;
            default: begin
                found_reg <= found_reg;
            end
        endcase
    end

    // Output register: load a result, drop valid once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.op == OP_OUT_LOAD) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_OUT_LOAD) begin
            m_found_reg <= found_reg;
            m_ftag_reg  <= ftag_reg;
            m_drop_reg  <= drop_reg;
            m_held_reg  <= HELD_W'(count_reg);
        end
    end

    // Status to the controller
    assign status.mode        = mode_reg;
    assign status.full        = (count_reg == CNT_W'(TABLE_DEPTH));
    assign status.query_zero  = (query_reg == '0);
    assign status.few_entries = (count_reg < CNT_W'(2));
    assign status.search_done = (lo_reg >= hi_reg);
    assign status.lo_zero     = (lo_reg == '0);
    assign status.lo_at_count = (lo_reg == count_reg);
    assign status.key_match   = (rd_addr_data_reg == query_reg);
    assign status.shift_more  = (sh_idx_reg > lo_reg);
    assign status.out_busy    = m_tvalid_reg && !m_tready;

    assign m_tvalid     = m_tvalid_reg;
    assign found        = m_found_reg;
    assign found_tag    = m_ftag_reg;
    assign dropped      = m_drop_reg;
    assign entries_held = m_held_reg;

endmodule

/* hw/rtl/address_range_tag_lookup_core.sv */
// Top level of the address range tag lookup block: sorted (address, tag)
// table with load, clear and floor lookup. Uses arl_pkg, arl_ctrl, arl_dp.
//
//  channel   direction  handshake          payload
//  s_        in         s_tvalid/s_tready  s_tuser: mode; s_tdata: entry_address,
//                                          entry_tag, query_address
//  m_        out        m_tvalid/m_tready  m_tdata: found, found_tag, dropped, entries_held
//
// One request at a time. A lookup runs up to two binary searches, one memory
// read per step; a load runs one binary search, then shifts each entry above
// the insertion point up by one, read then write, set by the single read and
// write port of the memories. Clear, a drop and a miss on a zero query or a
// short table skip the search. aresetn empties the table; entry memories are
// not cleared. A stalled result holds the controller; the next request is
// taken the cycle after it is staged.
module address_range_tag_lookup_core
    import arl_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [1:0] mode
    input  logic [S_TUSER_W-1:0] s_tuser,
    // [63:0] entry_address, [83:64] entry_tag, [147:84] query_address,
    // [151:148] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] found, [20:1] found_tag, [21] dropped, [34:22] entries_held,
    // [39:35] zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    dp_cmd_t           cmd;
    dp_status_t        status;
    logic              found;
    logic [TAG_W-1:0]  found_tag;
    logic              dropped;
    logic [HELD_W-1:0] entries_held;

    arl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    arl_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .mode          (s_tuser),
        .entry_address (s_tdata[S_ETAG_LSB-1:S_EADDR_LSB]),
        .entry_tag     (s_tdata[S_QADDR_LSB-1:S_ETAG_LSB]),
        .query_address (s_tdata[S_USED_W-1:S_QADDR_LSB]),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .found         (found),
        .found_tag     (found_tag),
        .dropped       (dropped),
        .entries_held  (entries_held)
    );

    // Pack the result
    assign m_tdata = M_TDATA_W'({entries_held, dropped, found_tag, found});

    // One request in flight: no back-to-back accepts
    a_single_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while previous one in progress");

    // A result never reports both found and dropped
    a_found_not_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[M_FOUND_LSB]) |-> !m_tdata[M_DROP_LSB])
        else $error("result both found and dropped");

    // Not-found results carry a zero tag
    a_tag_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[M_FOUND_LSB]) |-> (m_tdata[M_DROP_LSB-1:M_FTAG_LSB] == '0))
        else $error("nonzero tag without a match");

    // Drop is only issued on a full table
    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_SET_DROP) |-> (status.full && status.mode == MODE_LOAD))
        else $error("drop flagged on a non-full table");

endmodule

/* tb/testbench.sv */
// Testbench for address_range_tag_lookup_core: drives load, lookup, clear and
// unused-mode requests, predicts each result with a shadow copy of the sorted
// table and checks every result field. Depends on arl_pkg and the core RTL.
module testbench;
    import arl_pkg::*;

    localparam int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH;
    localparam int          STALL_LIMIT = 20000;
    localparam int          SHOW_LIMIT  = 100;
    localparam int          FILL_COUNT  = 128;

    typedef struct packed {
        mode_t              mode;
        logic [ADDR_W-1:0]  eaddr;
        logic [TAG_W-1:0]   etag;
        logic [ADDR_W-1:0]  qaddr;
    } request_t;

    typedef struct packed {
        logic               found;
        logic [TAG_W-1:0]   ftag;
        logic               dropped;
        logic [HELD_W-1:0]  held;
    } outcome_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Shadow copy of the sorted table
    logic [ADDR_W-1:0] shadow_addr [TABLE_DEPTH];
    logic [TAG_W-1:0]  shadow_tag  [TABLE_DEPTH];
    int                shadow_count = 0;

    outcome_t outcome_q[$];
    int       error_count   = 0;
    int       result_count  = 0;
    int       send_idle_max = 18;
    int       recv_idle_max = 18;
    int       quiet_cycles  = 0;

    address_range_tag_lookup_core #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tuser (s_tuser),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Apply one request to the shadow table and return the result it yields
    function automatic outcome_t table_outcome(request_t req);
        outcome_t         res;
        int               pos;
        int               idx;
        logic [ADDR_W-1:0] floor_addr;
        res = '0;
        case (req.mode)
            MODE_LOAD: begin
                if (shadow_count >= TABLE_DEPTH) begin
                    res.dropped = 1'b1;
                end else begin
                    // insert after every entry with an equal address
                    pos = shadow_count;
                    while (pos > 0 && shadow_addr[pos-1] > req.eaddr) pos--;
                    for (idx = shadow_count; idx > pos; idx--) begin
                        shadow_addr[idx] = shadow_addr[idx-1];
                        shadow_tag[idx]  = shadow_tag[idx-1];
                    end
                    shadow_addr[pos] = req.eaddr;
                    shadow_tag[pos]  = req.etag;
                    shadow_count++;
                end
            end
            MODE_LOOKUP: begin
                if (req.qaddr != '0 && shadow_count >= 2 &&
                    req.qaddr >= shadow_addr[0] &&
                    req.qaddr <= shadow_addr[shadow_count-1]) begin
                    // floor entry, then the first entry sharing its address
                    idx = shadow_count - 1;
                    while (shadow_addr[idx] > req.qaddr) idx--;
                    floor_addr = shadow_addr[idx];
                    while (idx > 0 && shadow_addr[idx-1] == floor_addr) idx--;
                    res.found = 1'b1;
                    res.ftag  = shadow_tag[idx];
                end
            end
            MODE_CLEAR: shadow_count = 0;
            default: ;
        endcase
        res.held = shadow_count[HELD_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        error_count++;
        if (error_count <= SHOW_LIMIT) begin
            $display("mismatch in result %0d: %s got %0h want %0h",
                     result_count, what, got, want);
        end
    endtask

    // Send one request after a random gap and record its predicted result
    task automatic send_request(request_t req);
        int gap;
        gap = $urandom_range(0, send_idle_max);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata = '0;
        s_tuser = req.mode;
        s_tdata[S_EADDR_LSB +: ADDR_W] = req.eaddr;
        s_tdata[S_ETAG_LSB  +: TAG_W]  = req.etag;
        s_tdata[S_QADDR_LSB +: ADDR_W] = req.qaddr;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        outcome_q.push_back(table_outcome(req));
        @(negedge aclk);
    endtask

    task automatic load_entry(logic [ADDR_W-1:0] addr, logic [TAG_W-1:0] tag);
        send_request('{MODE_LOAD, addr, tag, {$urandom, $urandom}});
    endtask

    task automatic lookup_addr(logic [ADDR_W-1:0] query);
        send_request('{MODE_LOOKUP, {$urandom, $urandom}, TAG_W'($urandom), query});
    endtask

    task automatic clear_table();
        send_request('{MODE_CLEAR, {$urandom, $urandom}, TAG_W'($urandom),
                       {$urandom, $urandom}});
    endtask

    task automatic ignored_request();
        send_request('{MODE_NONE, {$urandom, $urandom}, TAG_W'($urandom),
                       {$urandom, $urandom}});
    endtask

    function automatic int choose_idle_span();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 4;
            default: return 18;
        endcase
    endfunction

    // Field extremes, every mode and each not-found case
    task automatic test_directed();
        send_idle_max = 18;
        recv_idle_max = 18;
        clear_table();
        lookup_addr(64'h1000);
        load_entry(64'h1000, '1);
        lookup_addr(64'h1000);
        load_entry('0, '0);
        lookup_addr('0);
        lookup_addr(64'h0fff);
        load_entry(64'h1000, 20'h12345);
        lookup_addr(64'h1000);
        lookup_addr(64'h1001);
        load_entry('1, 20'habcde);
        lookup_addr('1);
        lookup_addr(64'hffff_ffff_ffff_fffe);
        ignored_request();
        clear_table();
        lookup_addr(64'h5);
        load_entry(64'h500, 20'h1);
        load_entry(64'h900, 20'h2);
        lookup_addr(64'h4ff);
        lookup_addr(64'h901);
        lookup_addr(64'h900);
        load_entry(64'h700, 20'h3);
        lookup_addr(64'h8ff);
        ignored_request();
        clear_table();
    endtask

    // Fill a block of entries in ascending order with pairs of equal
    // addresses, then insert at both ends and probe
    task automatic test_sorted_fill();
        logic [ADDR_W-1:0] last_addr;
        send_idle_max = 0;
        recv_idle_max = 0;
        clear_table();
        for (int i = 0; i < FILL_COUNT; i++) begin
            load_entry(64'h40 + 64'(i / 2) * 64'h20, TAG_W'(i));
        end
        last_addr = 64'h40 + 64'(FILL_COUNT / 2 - 1) * 64'h20;
        send_idle_max = 18;
        recv_idle_max = 18;
        lookup_addr(last_addr);
        lookup_addr(last_addr + 1);
        lookup_addr(64'h3f);
        lookup_addr(64'h65);
        load_entry(64'h10, 20'h55555);
        load_entry('1, 20'haaaaa);
        lookup_addr(last_addr);
        lookup_addr(64'h10);
        clear_table();
        lookup_addr(64'h65);
    endtask

    // Build small tables with random content and probe them
    task automatic test_random_traffic();
        request_t          req;
        int                held_cap;
        int                pick;
        logic [ADDR_W-1:0] addr_base;
        held_cap  = 32;
        addr_base = {$urandom, $urandom};
        for (int n = 0; n < 950; n++) begin
            if (n % 50 == 0) begin
                send_idle_max = choose_idle_span();
                recv_idle_max = choose_idle_span();
            end
            // entry address: near the base, a copy of a held one, fully random, or an extreme
            case ($urandom_range(0, 9))
                5, 6: req.eaddr = (shadow_count > 0) ?
                          shadow_addr[$urandom_range(0, shadow_count - 1)] : addr_base;
                7:       req.eaddr = {$urandom, $urandom};
                8:       req.eaddr = '0;
                9:       req.eaddr = '1;
                default: req.eaddr = addr_base + 64'($urandom_range(0, 4095));
            endcase
            // query: on or next to a held address, in range, random, zero, or outside
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    req.qaddr = (shadow_count > 0) ?
                        shadow_addr[$urandom_range(0, shadow_count - 1)] : addr_base;
                    case ($urandom_range(0, 2))
                        1: req.qaddr = req.qaddr + 64'd1;
                        2: req.qaddr = req.qaddr - 64'd1;
                        default: ;
                    endcase
                end
                7:       req.qaddr = {$urandom, $urandom};
                8:       req.qaddr = '0;
                9: begin
                    if (shadow_count == 0) req.qaddr = '1;
                    else if ($urandom_range(0, 1)) req.qaddr = shadow_addr[0] - 64'd1;
                    else req.qaddr = shadow_addr[shadow_count-1] + 64'd1;
                end
                default: req.qaddr = addr_base + 64'($urandom_range(0, 4200));
            endcase
            req.etag = TAG_W'($urandom);
            pick = $urandom_range(0, 99);
            if (shadow_count >= held_cap || pick < 3) begin
                req.mode  = MODE_CLEAR;
                held_cap  = $urandom_range(2, 96);
                addr_base = {$urandom, $urandom};
            end else if (pick < 45) begin
                req.mode = MODE_LOAD;
            end else if (pick < 93) begin
                req.mode = MODE_LOOKUP;
            end else begin
                req.mode = MODE_NONE;
            end
            send_request(req);
        end
    endtask

    // Accept results after random stalls and compare with the oldest prediction
    initial begin : result_checker
        outcome_t got;
        outcome_t want;
        int       stall;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            stall = $urandom_range(0, recv_idle_max);
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got.found   = m_tdata[M_FOUND_LSB];
            got.ftag    = m_tdata[M_FTAG_LSB +: TAG_W];
            got.dropped = m_tdata[M_DROP_LSB];
            got.held    = m_tdata[M_HELD_LSB +: HELD_W];
            if (outcome_q.size() == 0) begin
                report_mismatch("unexpected result", 64'(m_tdata), '0);
            end else begin
                want = outcome_q.pop_front();
                if (got.found !== want.found)
                    report_mismatch("found", 64'(got.found), 64'(want.found));
                if (got.ftag !== want.ftag)
                    report_mismatch("found_tag", 64'(got.ftag), 64'(want.ftag));
                if (got.dropped !== want.dropped)
                    report_mismatch("dropped", 64'(got.dropped), 64'(want.dropped));
                if (got.held !== want.held)
                    report_mismatch("entries_held", 64'(got.held), 64'(want.held));
            end
            result_count++;
            @(negedge aclk);
        end
    end

    // End the run when no request or result moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_directed();
        test_sorted_fill();
        test_random_traffic();
        s_tvalid = 1'b0;
        // drain, then leave room for any stray result
        while (outcome_q.size() != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);
        if (error_count == 0 && outcome_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
